/* rtl/mcr_pkg.sv */
package mcr_pkg;

  localparam int COORD_BITS    = 11;
  localparam int DEC_BITS      = COORD_BITS + 3;
  localparam int PIX_BITS      = 13;
  localparam int HALF_BITS     = 2;
  localparam int PSIZE_BITS    = 8;
  localparam int PT_BITS       = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = 1;
  localparam int QCNT_BITS     = 2;

  localparam int IN_FIELD_BITS  = 3 * COORD_BITS + HALF_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * PIX_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [PSIZE_BITS-1:0] PSIZE_RESET = PSIZE_BITS'(1);

  // decision increments of the midpoint step
  localparam logic [DEC_BITS-1:0] DEC_INC_EAST      = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_INC_SOUTHEAST = DEC_BITS'(5);

  localparam logic [PT_BITS-1:0] PT_FIRST_FULL  = PT_BITS'(0);
  localparam logic [PT_BITS-1:0] PT_FIRST_LEFT  = PT_BITS'(4);
  localparam logic [PT_BITS-1:0] PT_LAST_RIGHT  = PT_BITS'(3);
  localparam logic [PT_BITS-1:0] PT_LAST_FULL   = PT_BITS'(7);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [HALF_BITS-1:0] {
    HALF_FULL  = 2'd0,
    HALF_LEFT  = 2'd1,
    HALF_RIGHT = 2'd2,
    HALF_ALSO_FULL = 2'd3
  } half_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    half_e                 half;
    logic                  done;
  } job_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] py;
    logic [PIX_BITS-1:0] px;
  } pixel_t;

  function automatic logic [PT_BITS-1:0] first_point(half_e half);
    return (half == HALF_LEFT) ? PT_FIRST_LEFT : PT_FIRST_FULL;
  endfunction

  function automatic logic [PT_BITS-1:0] last_point(half_e half);
    return (half == HALF_RIGHT) ? PT_LAST_RIGHT : PT_LAST_FULL;
  endfunction

  // right half first, then the left half
  function automatic pixel_t point_at(job_t j, logic [PT_BITS-1:0] idx);
    logic [PIX_BITS-1:0] x;
    logic [PIX_BITS-1:0] y;
    logic [PIX_BITS-1:0] cx;
    logic [PIX_BITS-1:0] cy;
    pixel_t              p;
    x  = PIX_BITS'(j.x);
    y  = PIX_BITS'(j.y);
    cx = PIX_BITS'(j.cx);
    cy = PIX_BITS'(j.cy);
    case (idx)
      3'd0:    begin p.px = cx + x; p.py = cy + y; end
      3'd1:    begin p.px = cx + y; p.py = cy + x; end
      3'd2:    begin p.px = cx + y; p.py = cy - x; end
      3'd3:    begin p.px = cx + x; p.py = cy - y; end
      3'd4:    begin p.px = cx - x; p.py = cy - y; end
      3'd5:    begin p.px = cx - y; p.py = cy - x; end
      3'd6:    begin p.px = cx - y; p.py = cy + x; end
      default: begin p.px = cx - x; p.py = cy + y; end
    endcase
    return p;
  endfunction

endpackage

/* rtl/midpoint_circle_rasterizer.sv */
// Midpoint circle rasterizer. A start request (tuser 0) loads radius, center
// and half mode and yields the points of (0,r); each step request (tuser 1)
// advances the circle one midpoint step and yields its mirrored points: 8 for
// a full circle, 4 in left-only or right-only mode, right half first. Step
// requests while no circle runs are dropped without output. The front end
// takes one request per cycle while its two-entry job queue has room; the
// back end's point counter sends one point per cycle unless the output
// stalls, so the output port sets the sustained request rate. An idle
// block's first point passes the job queue, job register and output register.
// tlast marks a request's final point; tuser flags that the circle has finished.
module midpoint_circle_rasterizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // radius[10:0], center_x[21:11], center_y[32:22], half_select[34:33], zero pad
  input  logic [mcr_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  // op
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_x[12:0], pixel_y[25:13], zero pad
  output logic [mcr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  // circle_done
  output logic                              m_axis_tuser,
  // last_of_step
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mcr_pkg::PSIZE_BITS-1:0]    cfg_data_i
);

  localparam int CB = mcr_pkg::COORD_BITS;

  logic [mcr_pkg::PSIZE_BITS-1:0] point_size_q;
  logic                           q_full, q_valid, push, pop;
  mcr_pkg::job_t                  push_job, pop_job;
  logic [mcr_pkg::PIX_BITS-1:0]   pixel_x, pixel_y;

  // point size setting; always ready, not read by the rasterizer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_size_q <= mcr_pkg::PSIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      point_size_q <= cfg_data_i;
    end
  end

  mcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (mcr_pkg::op_e'(s_axis_tuser)),
    .radius_i   (s_axis_tdata[CB-1:0]),
    .center_x_i (s_axis_tdata[2*CB-1:CB]),
    .center_y_i (s_axis_tdata[3*CB-1:2*CB]),
    .half_i     (mcr_pkg::half_e'(s_axis_tdata[3*CB+mcr_pkg::HALF_BITS-1:3*CB])),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job)
  );

  mcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (pop_job)
  );

  mcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y),
    .last_o      (m_axis_tlast),
    .done_o      (m_axis_tuser)
  );

  assign m_axis_tdata = mcr_pkg::OUT_DATA_BITS'({pixel_y, pixel_x});

endmodule

/* rtl/mcr_front.sv */
module mcr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mcr_pkg::op_e                   op_i,
  input  logic [mcr_pkg::COORD_BITS-1:0] radius_i,
  input  logic [mcr_pkg::COORD_BITS-1:0] center_x_i,
  input  logic [mcr_pkg::COORD_BITS-1:0] center_y_i,
  input  mcr_pkg::half_e                 half_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output mcr_pkg::job_t                  job_o
);

  logic [mcr_pkg::COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [mcr_pkg::COORD_BITS-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [mcr_pkg::DEC_BITS-1:0]   dec_q, dec_d;
  mcr_pkg::half_e                 half_q, half_d;
  logic                           active_q, active_d;
  logic                           accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    dec_d    = dec_q;
    half_d   = half_q;
    active_d = active_q;
    push_o   = 1'b0;
    if (accept) begin
      if (op_i == mcr_pkg::OP_START) begin
        x_d      = '0;
        y_d      = radius_i;
        cx_d     = center_x_i;
        cy_d     = center_y_i;
        half_d   = half_i;
        dec_d    = mcr_pkg::DEC_BITS'(1) - mcr_pkg::DEC_BITS'(radius_i);
        active_d = radius_i != '0;
        push_o   = 1'b1;
      end else if (active_q) begin
        if (dec_q[mcr_pkg::DEC_BITS-1]) begin
          dec_d = dec_q + (mcr_pkg::DEC_BITS'(x_q) << 1) + mcr_pkg::DEC_INC_EAST;
        end else begin
          dec_d = dec_q + ((mcr_pkg::DEC_BITS'(x_q) - mcr_pkg::DEC_BITS'(y_q)) << 1)
                  + mcr_pkg::DEC_INC_SOUTHEAST;
          y_d   = y_q - mcr_pkg::COORD_BITS'(1);
        end
        x_d      = x_q + mcr_pkg::COORD_BITS'(1);
        active_d = y_d > x_d;
        push_o   = 1'b1;
      end
    end
  end

  always_comb begin
    job_o.x    = x_d;
    job_o.y    = y_d;
    job_o.cx   = cx_d;
    job_o.cy   = cy_d;
    job_o.half = half_d;
    job_o.done = !active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      dec_q    <= '0;
      half_q   <= mcr_pkg::HALF_FULL;
      active_q <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      dec_q    <= dec_d;
      half_q   <= half_d;
      active_q <= active_d;
    end
  end

endmodule

/* rtl/mcr_queue.sv */
module mcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mcr_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output mcr_pkg::job_t job_o
);

  mcr_pkg::job_t                  mem_q [mcr_pkg::QUEUE_DEPTH];
  logic [mcr_pkg::QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mcr_pkg::QCNT_BITS-1:0]  cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = cnt_q == mcr_pkg::QCNT_BITS'(mcr_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + mcr_pkg::QPTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + mcr_pkg::QPTR_BITS'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + mcr_pkg::QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - mcr_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/mcr_back.sv */
module mcr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         job_valid_i,
  input  mcr_pkg::job_t                job_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mcr_pkg::PIX_BITS-1:0] pixel_x_o,
  output logic [mcr_pkg::PIX_BITS-1:0] pixel_y_o,
  output logic                         last_o,
  output logic                         done_o
);

  mcr_pkg::job_t                job_q;
  logic                         busy_q, busy_d;
  logic [mcr_pkg::PT_BITS-1:0]  idx_q, idx_d;
  logic                         ovalid_q, ovalid_d;
  mcr_pkg::pixel_t              pix_q, pix;
  logic                         last_q, done_q;
  logic                         adv, fin, at_last;

  // while a job is loaded, a point is produced whenever the output register is free or drains
  assign adv     = busy_q && (!ovalid_q || out_ready_i);
  assign at_last = idx_q == mcr_pkg::last_point(job_q.half);
  assign fin     = adv && at_last;
  assign pop_o   = job_valid_i && (!busy_q || fin);
  assign pix     = mcr_pkg::point_at(job_q, idx_q);

  always_comb begin
    busy_d   = busy_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (adv) begin
      ovalid_d = 1'b1;
      idx_d    = idx_q + mcr_pkg::PT_BITS'(1);
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    if (fin) begin
      busy_d = 1'b0;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = mcr_pkg::first_point(job_i.half);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (adv) begin
      pix_q  <= pix;
      last_q <= at_last;
      done_q <= job_q.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign pixel_x_o   = pix_q.px;
  assign pixel_y_o   = pix_q.py;
  assign last_o      = last_q;
  assign done_o      = done_q;

endmodule

/* rtl/mcr_checker.sv */
module mcr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [mcr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tlast
);

  // a stalled point holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("output point changed while stalled");

  // points of one request come back to back and share the done flag
  a_step_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser)))
    else $error("gap or done change inside a step's points");

  // the queue fills only while the back end is streaming points
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no point pending");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
